FILE: hdl/imu_caf_pkg.sv
// Package for the IMU complementary attitude filter.
// Holds shared constants, the controller/datapath command types and the arctangent table.
// No dependencies.
`timescale 1ns / 1ps

package imu_caf_pkg;

  // Default build parameters
  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 24;

  // CORDIC working width and fixed constants
  localparam int CW = 40;
  localparam logic [29:0] GAIN_INV_Q30 = 30'd652032875;
  localparam logic signed [31:0] RAD2DEG_Q24 = 32'sd961263669;

  // Register map indexes
  localparam logic [1:0] REG_GYRO_WEIGHT   = 2'd0;
  localparam logic [1:0] REG_ACCEL_WEIGHT  = 2'd1;
  localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd2;

  // Register reset values
  localparam logic [15:0] GYRO_WEIGHT_RST   = 16'd32440;
  localparam logic [15:0] ACCEL_WEIGHT_RST  = 16'd328;
  localparam logic [23:0] SAMPLE_PERIOD_RST = 24'd16777;

  // Axis selectors
  localparam logic [1:0] AX_PITCH = 2'd0;
  localparam logic [1:0] AX_ROLL  = 2'd1;
  localparam logic [1:0] AX_YAW   = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_DELTA,
    OP_MAG_LOAD,
    OP_STEP,
    OP_GAIN_LO,
    OP_GAIN_HI,
    OP_ANG_LOAD,
    OP_TILT_SAVE,
    OP_BLEND_MUL,
    OP_BLEND_ADD,
    OP_YAW,
    OP_DEG_MUL,
    OP_DEG_FIN,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] axis;
    logic [4:0] step_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DELTA,
    ST_MAG_LOAD,
    ST_MAG_STEP,
    ST_GAIN_LO,
    ST_GAIN_HI,
    ST_ANG_LOAD,
    ST_ANG_STEP,
    ST_TILT_SAVE,
    ST_BLEND_MUL,
    ST_BLEND_ADD,
    ST_YAW,
    ST_DEG_MUL,
    ST_DEG_FIN,
    ST_OUT
  } ctrl_state_t;

  // atan(2^-i) in units of 2^-32 rad; small angles equal 2^-i
  function automatic logic signed [CW-1:0] atan_entry(input logic [4:0] i);
    logic signed [CW-1:0] r;
    case (i)
      5'd0:    r = 40'sd3373259426;
      5'd1:    r = 40'sd1991351318;
      5'd2:    r = 40'sd1052175346;
      5'd3:    r = 40'sd534100635;
      5'd4:    r = 40'sd268086748;
      5'd5:    r = 40'sd134174063;
      5'd6:    r = 40'sd67103403;
      5'd7:    r = 40'sd33553749;
      5'd8:    r = 40'sd16777131;
      5'd9:    r = 40'sd8388597;
      5'd10:   r = 40'sd4194303;
      default: r = CW'(64'd1 << (6'd32 - {1'b0, i}));
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/imu_caf_ctrl.sv
// Controller state machine for the IMU complementary attitude filter.
// Sequences the datapath through deltas, four CORDIC passes, blend and degree conversion.
// Depends on imu_caf_pkg.
`timescale 1ns / 1ps

module imu_caf_ctrl #(
  parameter int CORDIC_STEPS = imu_caf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   out_ready,
  input  imu_caf_pkg::dp_status_t status,
  output imu_caf_pkg::dp_cmd_t   cmd
);

  localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [SW-1:0] STEP_LAST = SW'(CORDIC_STEPS - 1);

  imu_caf_pkg::ctrl_state_t state, state_next;
  logic [1:0]    axis, axis_next;
  logic [SW-1:0] step, step_next;

  // State and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= imu_caf_pkg::ST_IDLE;
      axis  <= 2'd0;
      step  <= '0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      step  <= step_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    axis_next    = axis;
    step_next    = step;
    in_ready     = 1'b0;
    cmd.op       = imu_caf_pkg::OP_NONE;
    cmd.axis     = axis;
    cmd.step_idx = 5'(step);
    case (state)
      imu_caf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = imu_caf_pkg::OP_LATCH;
          axis_next  = imu_caf_pkg::AX_PITCH;
          state_next = imu_caf_pkg::ST_DELTA;
        end
      end
      imu_caf_pkg::ST_DELTA: begin
        cmd.op = imu_caf_pkg::OP_DELTA;
        if (axis == imu_caf_pkg::AX_YAW) begin
          axis_next  = imu_caf_pkg::AX_PITCH;
          state_next = imu_caf_pkg::ST_MAG_LOAD;
        end else begin
          axis_next = axis + 2'd1;
        end
      end
      imu_caf_pkg::ST_MAG_LOAD: begin
        cmd.op     = imu_caf_pkg::OP_MAG_LOAD;
        step_next  = '0;
        state_next = imu_caf_pkg::ST_MAG_STEP;
      end
      imu_caf_pkg::ST_MAG_STEP: begin
        cmd.op    = imu_caf_pkg::OP_STEP;
        step_next = step + SW'(1);
        if (step == STEP_LAST) begin
          state_next = imu_caf_pkg::ST_GAIN_LO;
        end
      end
      imu_caf_pkg::ST_GAIN_LO: begin
        cmd.op     = imu_caf_pkg::OP_GAIN_LO;
        state_next = imu_caf_pkg::ST_GAIN_HI;
      end
      imu_caf_pkg::ST_GAIN_HI: begin
        cmd.op     = imu_caf_pkg::OP_GAIN_HI;
        state_next = imu_caf_pkg::ST_ANG_LOAD;
      end
      imu_caf_pkg::ST_ANG_LOAD: begin
        cmd.op     = imu_caf_pkg::OP_ANG_LOAD;
        step_next  = '0;
        state_next = imu_caf_pkg::ST_ANG_STEP;
      end
      imu_caf_pkg::ST_ANG_STEP: begin
        cmd.op    = imu_caf_pkg::OP_STEP;
        step_next = step + SW'(1);
        if (step == STEP_LAST) begin
          state_next = imu_caf_pkg::ST_TILT_SAVE;
        end
      end
      imu_caf_pkg::ST_TILT_SAVE: begin
        cmd.op = imu_caf_pkg::OP_TILT_SAVE;
        if (axis == imu_caf_pkg::AX_PITCH) begin
          axis_next  = imu_caf_pkg::AX_ROLL;
          state_next = imu_caf_pkg::ST_MAG_LOAD;
        end else begin
          axis_next  = imu_caf_pkg::AX_PITCH;
          state_next = imu_caf_pkg::ST_BLEND_MUL;
        end
      end
      imu_caf_pkg::ST_BLEND_MUL: begin
        cmd.op     = imu_caf_pkg::OP_BLEND_MUL;
        state_next = imu_caf_pkg::ST_BLEND_ADD;
      end
      imu_caf_pkg::ST_BLEND_ADD: begin
        cmd.op = imu_caf_pkg::OP_BLEND_ADD;
        if (axis == imu_caf_pkg::AX_PITCH) begin
          axis_next  = imu_caf_pkg::AX_ROLL;
          state_next = imu_caf_pkg::ST_BLEND_MUL;
        end else begin
          axis_next  = imu_caf_pkg::AX_YAW;
          state_next = imu_caf_pkg::ST_YAW;
        end
      end
      imu_caf_pkg::ST_YAW: begin
        cmd.op     = imu_caf_pkg::OP_YAW;
        axis_next  = imu_caf_pkg::AX_PITCH;
        state_next = imu_caf_pkg::ST_DEG_MUL;
      end
      imu_caf_pkg::ST_DEG_MUL: begin
        cmd.op     = imu_caf_pkg::OP_DEG_MUL;
        state_next = imu_caf_pkg::ST_DEG_FIN;
      end
      imu_caf_pkg::ST_DEG_FIN: begin
        cmd.op = imu_caf_pkg::OP_DEG_FIN;
        if (axis == imu_caf_pkg::AX_YAW) begin
          state_next = imu_caf_pkg::ST_OUT;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = imu_caf_pkg::ST_DEG_MUL;
        end
      end
      imu_caf_pkg::ST_OUT: begin
        // Hold until the output register is free
        if (!status.out_full || out_ready) begin
          cmd.op     = imu_caf_pkg::OP_OUT;
          state_next = imu_caf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = imu_caf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/imu_caf_datapath.sv
// Datapath for the IMU complementary attitude filter.
// Shared CORDIC vectoring unit, gain and blend multipliers, angle state and output register.
// Depends on imu_caf_pkg.
`timescale 1ns / 1ps

module imu_caf_datapath #(
  parameter int ANGLE_FRAC_BITS = imu_caf_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  imu_caf_pkg::dp_cmd_t     cmd,
  output imu_caf_pkg::dp_status_t  status,
  input  logic [95:0]              in_data,
  input  logic [15:0]              gyro_gain,
  input  logic [15:0]              accel_gain,
  input  logic [23:0]              sample_period,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [95:0]              out_data
);

  localparam int CW = imu_caf_pkg::CW;
  localparam int DS = 36 - ANGLE_FRAC_BITS;
  localparam int TS = 32 - ANGLE_FRAC_BITS;
  localparam int GS = ANGLE_FRAC_BITS + 8;

  // Latched sample
  logic signed [15:0] ax, ay, az, wx, wy, wz;

  // CORDIC registers
  logic signed [CW-1:0] cx, cy, cz;
  logic                 zero_vec;
  logic [63:0]          gacc;

  // Angle state and intermediates
  logic signed [31:0] pitch_rad, roll_rad, yaw_rad;
  logic signed [33:0] dlt [3];
  logic signed [31:0] tilt_p, tilt_r;
  logic signed [51:0] prod_g;
  logic signed [48:0] prod_a;
  logic signed [63:0] dprod;
  logic signed [29:0] deg [3];

  // Combinational terms
  logic signed [CW-1:0] dx, dy, at_e;
  logic signed [15:0]   w_sel;
  logic signed [41:0]   dt_prod;
  logic signed [41:0]   dt_shift;
  logic [16:0]          abs_a, abs_b;
  logic signed [16:0]   n_sel;
  logic [63:0]          gacc_rnd;
  logic [33:0]          mag;
  logic signed [CW-1:0] z_rnd;
  logic signed [CW-1:0] z_shift;
  logic signed [31:0]   ang_sel, tilt_sel;
  logic signed [34:0]   bsum;
  logic signed [52:0]   bacc;
  logic signed [37:0]   bres;
  logic signed [31:0]   bsat;
  logic signed [34:0]   ysum;
  logic signed [31:0]   ysat;
  logic signed [63:0]   dshift;
  logic signed [29:0]   dsat;

  assign status.out_full = out_valid;

  // CORDIC micro-rotation terms
  always_comb begin
    dx   = cy >>> cmd.step_idx;
    dy   = cx >>> cmd.step_idx;
    at_e = imu_caf_pkg::atan_entry(cmd.step_idx);
  end

  // Gyro increment: rate * dt rounded to the angle format
  always_comb begin
    case (cmd.axis)
      imu_caf_pkg::AX_PITCH: w_sel = wx;
      imu_caf_pkg::AX_ROLL:  w_sel = wy;
      default:               w_sel = wz;
    endcase
    dt_prod  = 42'(w_sel) * 42'($signed({1'b0, sample_period}));
    dt_shift = (dt_prod + (42'sd1 <<< (DS - 1))) >>> DS;
  end

  // Operand selection for the two CORDIC passes
  always_comb begin
    abs_a = (cmd.axis == imu_caf_pkg::AX_PITCH) ?
            (ax[15] ? 17'(-{ax[15], ax}) : {1'b0, ax}) :
            (ay[15] ? 17'(-{ay[15], ay}) : {1'b0, ay});
    abs_b = az[15] ? 17'(-{az[15], az}) : {1'b0, az};
    n_sel = (cmd.axis == imu_caf_pkg::AX_PITCH) ? {ay[15], ay} : -{ax[15], ax};
    gacc_rnd = gacc + (64'd1 << 29);
    mag      = gacc_rnd[63:30];
    z_rnd    = cz + (CW'(1) <<< (TS - 1));
    z_shift  = z_rnd >>> TS;
  end

  // Blend and yaw integration with saturation
  always_comb begin
    ang_sel  = (cmd.axis == imu_caf_pkg::AX_PITCH) ? pitch_rad :
               (cmd.axis == imu_caf_pkg::AX_ROLL) ? roll_rad : yaw_rad;
    tilt_sel = (cmd.axis == imu_caf_pkg::AX_PITCH) ? tilt_p : tilt_r;
    bsum = 35'(ang_sel) + 35'(dlt[cmd.axis]);
    bacc = 53'(prod_g) + 53'(prod_a) + (53'sd1 <<< 14);
    bres = 38'(bacc >>> 15);
    if (bres > 38'sh7FFFFFFF)       bsat = 32'sh7FFFFFFF;
    else if (bres < -38'sh80000000) bsat = -32'sh80000000;
    else                            bsat = bres[31:0];
    ysum = 35'(yaw_rad) + 35'(dlt[2]);
    if (ysum > 35'sh7FFFFFFF)       ysat = 32'sh7FFFFFFF;
    else if (ysum < -35'sh80000000) ysat = -32'sh80000000;
    else                            ysat = ysum[31:0];
  end

  // Degree conversion rounding and saturation
  always_comb begin
    dshift = (dprod + (64'sd1 <<< (GS - 1))) >>> GS;
    if (dshift > 64'sd536870911)       dsat = 30'sh1FFFFFFF;
    else if (dshift < -64'sd536870912) dsat = -30'sh20000000;
    else                               dsat = dshift[29:0];
  end

  // Angle state and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_rad <= '0;
      roll_rad  <= '0;
      yaw_rad   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == imu_caf_pkg::OP_OUT)  out_valid <= 1'b1;
      else if (out_valid && out_ready)    out_valid <= 1'b0;
      case (cmd.op)
        imu_caf_pkg::OP_BLEND_ADD: begin
          if (cmd.axis == imu_caf_pkg::AX_PITCH) pitch_rad <= bsat;
          else                                   roll_rad  <= bsat;
        end
        imu_caf_pkg::OP_YAW: yaw_rad <= ysat;
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      imu_caf_pkg::OP_LATCH: begin
        ax <= in_data[15:0];
        ay <= in_data[31:16];
        az <= in_data[47:32];
        wx <= in_data[63:48];
        wy <= in_data[79:64];
        wz <= in_data[95:80];
      end
      imu_caf_pkg::OP_DELTA: dlt[cmd.axis] <= dt_shift[33:0];
      imu_caf_pkg::OP_MAG_LOAD: begin
        cx <= {7'd0, abs_a, 16'd0};
        cy <= {7'd0, abs_b, 16'd0};
        cz <= '0;
      end
      imu_caf_pkg::OP_STEP: begin
        if (!cy[CW-1]) begin
          cx <= cx + dx;
          cy <= cy - dy;
          cz <= cz + at_e;
        end else begin
          cx <= cx - dx;
          cy <= cy + dy;
          cz <= cz - at_e;
        end
      end
      imu_caf_pkg::OP_GAIN_LO:
        gacc <= 64'(cx[16:0]) * 64'(imu_caf_pkg::GAIN_INV_Q30);
      imu_caf_pkg::OP_GAIN_HI:
        gacc <= gacc + ((64'(cx[CW-1:17]) * 64'(imu_caf_pkg::GAIN_INV_Q30)) << 17);
      imu_caf_pkg::OP_ANG_LOAD: begin
        cx       <= {6'd0, mag};
        cy       <= {{7{n_sel[16]}}, n_sel, 16'd0};
        cz       <= '0;
        zero_vec <= (n_sel == 17'sd0) && (mag == 34'd0);
      end
      imu_caf_pkg::OP_TILT_SAVE: begin
        if (cmd.axis == imu_caf_pkg::AX_PITCH) tilt_p <= zero_vec ? '0 : z_shift[31:0];
        else                                   tilt_r <= zero_vec ? '0 : z_shift[31:0];
      end
      imu_caf_pkg::OP_BLEND_MUL: begin
        prod_g <= 52'(bsum) * 52'($signed({1'b0, gyro_gain}));
        prod_a <= 49'(tilt_sel) * 49'($signed({1'b0, accel_gain}));
      end
      imu_caf_pkg::OP_DEG_MUL: dprod <= 64'(ang_sel) * 64'(imu_caf_pkg::RAD2DEG_Q24);
      imu_caf_pkg::OP_DEG_FIN: deg[cmd.axis] <= dsat;
      imu_caf_pkg::OP_OUT: out_data <= {6'd0, deg[2], deg[1], deg[0]};
      default: ;
    endcase
  end

endmodule

FILE: hdl/imu_complementary_attitude_filter.sv
// IMU complementary attitude filter: one result beat per input beat.
// For each input beat the four passes of the shared CORDIC unit run one after another.
// A new input is taken only once the previous result is loaded into the output register,
// and it may be taken while that result still waits.
// Synchronous active-high reset zeroes the stored angles and loads register defaults.
`timescale 1ns / 1ps

module imu_complementary_attitude_filter #(
  parameter int CORDIC_STEPS    = imu_caf_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = imu_caf_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z (16 bits each, low first)
  input  logic [95:0] s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // pitch_deg, roll_deg, yaw_deg (30 bits each, low first), 6 zero bits on top
  output logic [95:0] m_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] gyro_gain;
  logic [15:0] accel_gain;
  logic [23:0] sample_period;

  imu_caf_pkg::dp_cmd_t    cmd;
  imu_caf_pkg::dp_status_t status;

  assign pready = 1'b1;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_gain     <= imu_caf_pkg::GYRO_WEIGHT_RST;
      accel_gain    <= imu_caf_pkg::ACCEL_WEIGHT_RST;
      sample_period <= imu_caf_pkg::SAMPLE_PERIOD_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        imu_caf_pkg::REG_GYRO_WEIGHT:   gyro_gain     <= pwdata[15:0];
        imu_caf_pkg::REG_ACCEL_WEIGHT:  accel_gain    <= pwdata[15:0];
        imu_caf_pkg::REG_SAMPLE_PERIOD: sample_period <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (paddr[3:2])
      imu_caf_pkg::REG_GYRO_WEIGHT:   prdata = {16'd0, gyro_gain};
      imu_caf_pkg::REG_ACCEL_WEIGHT:  prdata = {16'd0, accel_gain};
      imu_caf_pkg::REG_SAMPLE_PERIOD: prdata = {8'd0, sample_period};
      default:                        prdata = '0;
    endcase
  end

  imu_caf_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_ready(m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  imu_caf_datapath #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .in_data      (s_tdata),
    .gyro_gain    (gyro_gain),
    .accel_gain   (accel_gain),
    .sample_period(sample_period),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_data     (m_tdata)
  );

endmodule
